FILE: rtl/mcitt_pkg.sv
package mcitt_pkg;

  localparam int ENTRIES   = 16;
  localparam int SLOT_BITS = 8;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam logic [7:0] SLOT_MASK = 8'((64'd1 << SLOT_BITS) - 64'd1);

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 40;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [2:0] KIND_ADDED  = 3'd0;
  localparam logic [2:0] KIND_FULL   = 3'd1;
  localparam logic [2:0] KIND_CANCEL = 3'd2;
  localparam logic [2:0] KIND_FIRED  = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] interval;
    logic [31:0] remaining;
    logic        one_shot;
    logic [7:0]  frame;
    logic        cancelled;
  } entry_t;

  typedef struct packed {
    logic        is_tick;
    logic        hit;
    logic [31:0] cancel_id;
    logic [31:0] delta;
    logic [7:0]  frame;
  } cmd_t;

  typedef struct packed {
    entry_t entry;
    logic   keep;
    logic   fire;
    logic   hit;
  } proc_res_t;

endpackage

FILE: rtl/mcitt_cell.sv
module mcitt_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  mcitt_pkg::entry_t nbr,
  input  mcitt_pkg::entry_t ext,
  output mcitt_pkg::entry_t q
);
  import mcitt_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      q <= ext;
    end else if (shift) begin
      q <= nbr;
    end
  end

endmodule

FILE: rtl/mcitt_proc.sv
module mcitt_proc (
  input  mcitt_pkg::entry_t    head,
  input  mcitt_pkg::cmd_t      cmd,
  output mcitt_pkg::proc_res_t res
);
  import mcitt_pkg::*;

  logic [31:0] rem;

  always_comb begin
    res.entry = head;
    res.keep  = 1'b1;
    res.fire  = 1'b0;
    res.hit   = 1'b0;
    rem       = (head.remaining > cmd.delta) ? head.remaining - cmd.delta : 32'd0;
    if (cmd.is_tick) begin
      if (head.cancelled) begin
        res.keep = 1'b0;
      end else begin
        res.entry.frame = cmd.frame;
        if (rem == 32'd0 && head.frame != cmd.frame) begin
          res.fire = 1'b1;
          if (head.one_shot) begin
            res.entry.cancelled = 1'b1;
            res.keep = 1'b0;
          end else begin
            rem = head.interval;
          end
        end
        res.entry.remaining = rem;
      end
    end else if (!cmd.hit && head.id == cmd.cancel_id) begin
      res.entry.cancelled = 1'b1;
      res.hit = 1'b1;
    end
  end

endmodule

FILE: rtl/multi_channel_interval_timer_table.sv
// Timer table: a row of ENTRIES cells, oldest entry at the head. Add answers
// in the cycle after its beat is taken. Cancel and tick pop the head cell once
// per cycle while the output is not stalled, through one shared update unit,
// and write kept entries back behind the not-yet-visited ones, so the table
// stays compacted in order. A new beat is taken only when the block is idle
// and the output is empty.
module multi_channel_interval_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // interval_ms[31:0], one_shot[32], cancel_id[64:33], delta_ms[96:65],
  // frame_slot[104:97], zero fill
  input  logic [mcitt_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // task_id[31:0], found[32], zero fill
  output logic [mcitt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);
  import mcitt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  left;
  logic [CNT_W-1:0]  kept;
  logic [31:0]       next_id;
  cmd_t              cmd;
  logic [31:0]       out_id;
  logic              out_found;

  entry_t            cell_q [ENTRIES];
  logic [ENTRIES-1:0] cell_ld;
  entry_t            ext;
  entry_t            new_entry;
  proc_res_t         res;

  logic              accept;
  logic              adv;
  logic              out_load;
  logic [CNT_W-1:0]  wr_full;
  logic [IDX_W-1:0]  wr;
  logic              full;
  logic [7:0]        in_frame;

  assign in_frame      = s_axis_tdata[104:97] & SLOT_MASK;
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign full          = (count == CNT_W'(ENTRIES));
  assign wr_full       = left + kept - CNT_W'(1);
  assign wr            = wr_full[IDX_W-1:0];
  assign m_axis_tdata  = {7'd0, out_found, out_id};
  // a new output beat is loaded this cycle
  assign out_load      = (accept && s_axis_tuser == MODE_ADD) ||
                         (state == ST_RUN && adv && res.fire) ||
                         (state == ST_FIN && adv);

  always_comb begin
    new_entry.id        = next_id;
    new_entry.interval  = s_axis_tdata[31:0];
    new_entry.remaining = s_axis_tdata[31:0];
    new_entry.one_shot  = s_axis_tdata[32];
    new_entry.frame     = in_frame;
    new_entry.cancelled = 1'b0;
    ext = (state == ST_RUN) ? res.entry : new_entry;
  end

  mcitt_proc u_proc (
    .head (cell_q[0]),
    .cmd  (cmd),
    .res  (res)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign cell_ld[i] =
      (accept && s_axis_tuser == MODE_ADD && !full && count[IDX_W-1:0] == IDX_W'(i)) ||
      (state == ST_RUN && adv && res.keep && wr == IDX_W'(i));
    mcitt_cell u_cell (
      .clk   (clk),
      .shift (state == ST_RUN && adv),
      .load  (cell_ld[i]),
      .nbr   ((i == ENTRIES - 1) ? ext : cell_q[(i + 1) % ENTRIES]),
      .ext   (ext),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      next_id       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd.is_tick   <= (s_axis_tuser == MODE_TICK);
            cmd.hit       <= 1'b0;
            cmd.cancel_id <= s_axis_tdata[64:33];
            cmd.delta     <= s_axis_tdata[96:65];
            cmd.frame     <= in_frame;
            left          <= count;
            kept          <= '0;
            unique case (s_axis_tuser)
              MODE_ADD: begin
                m_axis_tlast  <= 1'b1;
                out_found     <= 1'b0;
                if (full) begin
                  m_axis_tuser <= KIND_FULL;
                  out_id       <= '0;
                end else begin
                  m_axis_tuser <= KIND_ADDED;
                  out_id       <= next_id;
                  next_id      <= next_id + 32'd1;
                  count        <= count + CNT_W'(1);
                end
              end
              MODE_CANCEL, MODE_TICK: begin
                state <= (count == '0) ? ST_FIN : ST_RUN;
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (res.fire) begin
              m_axis_tlast  <= 1'b0;
              m_axis_tuser  <= KIND_FIRED;
              out_id        <= cell_q[0].id;
              out_found     <= 1'b0;
            end
            cmd.hit <= cmd.hit | res.hit;
            kept    <= kept + CNT_W'(res.keep);
            left    <= left - CNT_W'(1);
            if (left == CNT_W'(1)) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (adv) begin
            m_axis_tlast  <= 1'b1;
            if (cmd.is_tick) begin
              m_axis_tuser <= KIND_DONE;
              out_id       <= '0;
              out_found    <= 1'b0;
            end else begin
              m_axis_tuser <= KIND_CANCEL;
              out_id       <= cmd.cancel_id;
              out_found    <= cmd.hit;
            end
            count <= kept;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/mcitt_chk.sv
module mcitt_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import mcitt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("output beat dropped while stalled");

  a_rst: assert property (@(posedge clk) !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result waits");

  a_fired_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_FIRED |-> !m_axis_tlast)
    else $error("fired beat marked last");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_ADDED || m_axis_tuser == KIND_FULL ||
    m_axis_tuser == KIND_CANCEL || m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
    else $error("closing beat not marked last");

endmodule

bind multi_channel_interval_timer_table mcitt_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
